### rtl/dtpw_pkg.sv
// Shared types and constants of the dual task progress watchdog.
package dtpw_pkg;

    localparam int TIME_W   = 32;
    localparam int CNT_W    = 32;
    localparam int CFG_W    = 16;
    localparam int PHASE_W  = 8;
    localparam int MODE_W   = 3;
    localparam int STALL_W  = 2;
    localparam int LOW_W    = 8;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_W-1:0] REFRESH_PERIOD_RST = CFG_W'(100);
    localparam logic [CFG_W-1:0] STALL_LIMIT_RST    = CFG_W'(2 * 100);

    // Bit positions inside the stall flags.
    localparam int FLAG_A_BIT = 0;
    localparam int FLAG_B_BIT = 1;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK     = 3'd0,
        MODE_REPORT_A = 3'd1,
        MODE_REPORT_B = 3'd2,
        MODE_PHASE_A  = 3'd3,
        MODE_PHASE_B  = 3'd4
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REFRESH_PERIOD = 1'b0,
        CFG_STALL_LIMIT    = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [CFG_W-1:0] refresh_period;
        logic [CFG_W-1:0] stall_limit;
    } t_cfg;

    typedef struct packed {
        logic               refresh_pulse;
        logic               snapshot_write;
        logic [STALL_W-1:0] stall_flags;
        logic               monitor_active;
        logic [PHASE_W-1:0] phase_a;
        logic [PHASE_W-1:0] phase_b;
        logic [LOW_W-1:0]   count_a_low;
        logic [LOW_W-1:0]   count_b_low;
    } t_result;

endpackage

### rtl/dtpw_if.sv
// Handshake channel interfaces of the dual task progress watchdog.
interface dtpw_in_if import dtpw_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [MODE_W-1:0]  mode;
    logic [PHASE_W-1:0] phase_code;

    modport source (output valid, output mode, output phase_code, input ready);
    modport sink   (input valid, input mode, input phase_code, output ready);
endinterface

interface dtpw_out_if import dtpw_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               refresh_pulse;
    logic               snapshot_write;
    logic [STALL_W-1:0] stall_flags;
    logic               monitor_active;
    logic [PHASE_W-1:0] phase_a;
    logic [PHASE_W-1:0] phase_b;
    logic [LOW_W-1:0]   count_a_low;
    logic [LOW_W-1:0]   count_b_low;

    modport source (output valid, output refresh_pulse, output snapshot_write,
                    output stall_flags, output monitor_active, output phase_a,
                    output phase_b, output count_a_low, output count_b_low,
                    input ready);
    modport sink   (input valid, input refresh_pulse, input snapshot_write,
                    input stall_flags, input monitor_active, input phase_a,
                    input phase_b, input count_a_low, input count_b_low,
                    output ready);
endinterface

interface dtpw_cfg_if import dtpw_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/dual_task_progress_watchdog.sv
// Top level of the dual task progress watchdog: input stage, core and result register.
//
// This block supervises two software tasks, A and B, and decides when a
// hardware watchdog may be refreshed. Each input transaction is a millisecond
// tick, a progress report from A or B, or a new phase code for A or B, and
// each one produces exactly one result transaction holding the refresh
// strobe, the snapshot write strobe and a snapshot of the supervisor state
// after that transaction. The block takes one transaction per clock while
// the result side does not stall it: an input register feeds combinational
// update logic (two 32-bit wrap-around subtracts and compares plus two
// 32-bit equality checks) whose outcome is stored in the result register,
// so a result is presented once the input register and then the result
// register have loaded, and the next input may follow immediately. Back-pressure
// on the result side holds the input register, and the input stays ready
// while that register is empty or moving. The two configuration registers,
// refresh period and stall limit, are written through their own channel,
// which is always ready, and should only be written while the block is idle.
module dual_task_progress_watchdog import dtpw_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dtpw_in_if.sink    i_in,
    dtpw_cfg_if.sink   i_cfg,
    dtpw_out_if.source o_out
);

    t_cfg               w_cfg;
    t_result            w_result;

    logic               r_in_valid;
    logic [MODE_W-1:0]  r_in_mode;
    logic [PHASE_W-1:0] r_in_code;

    logic               r_out_valid;
    t_result            r_out;

    logic               w_out_free;
    logic               w_fire;
    logic               w_in_take;

    // The result register can load when it is empty or being drained now.
    assign w_out_free = !r_out_valid || o_out.ready;
    // The buffered transaction is processed and commits its state update.
    assign w_fire     = r_in_valid && w_out_free;
    assign i_in.ready = !r_in_valid || w_fire;
    assign w_in_take  = i_in.valid && i_in.ready;

    dtpw_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    dtpw_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (w_fire),
        .i_mode       (r_in_mode),
        .i_phase_code (r_in_code),
        .i_cfg        (w_cfg),
        .o_result     (w_result)
    );

    // Input register: valid is control, payload loads without reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_mode <= i_in.mode;
            r_in_code <= i_in.phase_code;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_result;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.refresh_pulse  = r_out.refresh_pulse;
    assign o_out.snapshot_write = r_out.snapshot_write;
    assign o_out.stall_flags    = r_out.stall_flags;
    assign o_out.monitor_active = r_out.monitor_active;
    assign o_out.phase_a        = r_out.phase_a;
    assign o_out.phase_b        = r_out.phase_b;
    assign o_out.count_a_low    = r_out.count_a_low;
    assign o_out.count_b_low    = r_out.count_b_low;

    // A refresh always comes with monitoring on and all stall flags cleared.
    a_refresh_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.refresh_pulse)
            |-> (o_out.monitor_active && o_out.snapshot_write && o_out.stall_flags == '0))
        else $error("refresh issued with stall flags set or monitoring off");

    // An accepted input is held in the input register on the next cycle.
    a_in_captured: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_take |=> r_in_valid)
        else $error("accepted input transaction was dropped");

    // A buffered transaction that could not be processed is still there.
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_fire) |=> (r_in_valid && $stable(r_in_mode)))
        else $error("stalled input transaction was lost or changed");

    // Processing a transaction always leaves a result waiting.
    a_fire_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> r_out_valid)
        else $error("processed transaction produced no result");

endmodule

### rtl/dtpw_cfg.sv
// Configuration register file of the dual task progress watchdog.
module dtpw_cfg import dtpw_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    dtpw_cfg_if.sink     i_cfg,
    output t_cfg         o_cfg
);

    t_cfg r_cfg;

    // Writes are always taken.
    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.refresh_period <= REFRESH_PERIOD_RST;
            r_cfg.stall_limit    <= STALL_LIMIT_RST;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_REFRESH_PERIOD: r_cfg.refresh_period <= i_cfg.data;
                CFG_STALL_LIMIT:    r_cfg.stall_limit    <= i_cfg.data;
            endcase
        end
    end

endmodule

### rtl/dtpw_core.sv
// Supervisor state and the per-transaction update logic.
module dtpw_core import dtpw_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  logic [MODE_W-1:0]  i_mode,
    input  logic [PHASE_W-1:0] i_phase_code,
    input  t_cfg               i_cfg,
    output t_result            o_result
);

    logic [TIME_W-1:0]  r_time, n_time;
    logic [TIME_W-1:0]  r_last_refresh, n_last_refresh;
    logic [TIME_W-1:0]  r_last_report_a, n_last_report_a;
    logic [CNT_W-1:0]   r_count_a, n_count_a;
    logic [CNT_W-1:0]   r_count_b, n_count_b;
    logic [CNT_W-1:0]   r_seen_a, n_seen_a;
    logic [CNT_W-1:0]   r_seen_b, n_seen_b;
    logic [STALL_W-1:0] r_stalled, n_stalled;
    logic               r_monitoring, n_monitoring;
    logic [PHASE_W-1:0] r_phase_a, n_phase_a;
    logic [PHASE_W-1:0] r_phase_b, n_phase_b;

    logic [TIME_W-1:0]  w_time_inc;
    logic [TIME_W-1:0]  w_elapsed;
    logic [TIME_W-1:0]  w_age_a;
    logic               w_period_due;
    logic               w_counts_live;
    logic               w_same_a;
    logic               w_same_b;
    logic               w_a_too_old;
    logic               w_pulse;
    logic               w_write;

    // Differences wrap modulo the counter width, as does the tick count.
    assign w_time_inc    = r_time + TIME_W'(1);
    assign w_elapsed     = w_time_inc - r_last_refresh;
    assign w_age_a       = r_time - r_last_report_a;
    assign w_period_due  = w_elapsed >= TIME_W'(i_cfg.refresh_period);
    assign w_counts_live = (r_count_a != '0) && (r_count_b != '0);
    assign w_same_a      = r_count_a == r_seen_a;
    assign w_same_b      = r_count_b == r_seen_b;
    assign w_a_too_old   = w_age_a >= TIME_W'(i_cfg.stall_limit);

    always_comb begin
        n_time          = r_time;
        n_last_refresh  = r_last_refresh;
        n_last_report_a = r_last_report_a;
        n_count_a       = r_count_a;
        n_count_b       = r_count_b;
        n_seen_a        = r_seen_a;
        n_seen_b        = r_seen_b;
        n_stalled       = r_stalled;
        n_monitoring    = r_monitoring;
        n_phase_a       = r_phase_a;
        n_phase_b       = r_phase_b;
        w_pulse         = 1'b0;
        w_write         = 1'b0;
        unique case (i_mode)
            MODE_TICK: begin
                n_time = w_time_inc;
                if (w_period_due && w_counts_live) begin
                    w_write = 1'b1;
                    if (r_monitoring && (w_same_a || w_same_b)) begin
                        // A task made no progress since the last refresh.
                        if (w_same_a) n_stalled[FLAG_A_BIT] = 1'b1;
                        if (w_same_b) n_stalled[FLAG_B_BIT] = 1'b1;
                    end else begin
                        n_stalled      = '0;
                        n_monitoring   = 1'b1;
                        n_seen_a       = r_count_a;
                        n_seen_b       = r_count_b;
                        n_last_refresh = w_time_inc;
                        w_pulse        = 1'b1;
                    end
                end
            end
            MODE_REPORT_A: begin
                n_count_a       = r_count_a + CNT_W'(1);
                n_last_report_a = r_time;
                w_write         = 1'b1;
            end
            MODE_REPORT_B: begin
                n_count_b = r_count_b + CNT_W'(1);
                if (r_monitoring && w_a_too_old) n_stalled[FLAG_A_BIT] = 1'b1;
                w_write = 1'b1;
            end
            MODE_PHASE_A: begin
                n_phase_a = i_phase_code;
                w_write   = 1'b1;
            end
            MODE_PHASE_B: begin
                n_phase_b = i_phase_code;
                w_write   = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time          <= '0;
            r_last_refresh  <= '0;
            r_last_report_a <= '0;
            r_count_a       <= '0;
            r_count_b       <= '0;
            r_seen_a        <= '0;
            r_seen_b        <= '0;
            r_stalled       <= '0;
            r_monitoring    <= 1'b0;
            r_phase_a       <= '0;
            r_phase_b       <= '0;
        end else if (i_fire) begin
            r_time          <= n_time;
            r_last_refresh  <= n_last_refresh;
            r_last_report_a <= n_last_report_a;
            r_count_a       <= n_count_a;
            r_count_b       <= n_count_b;
            r_seen_a        <= n_seen_a;
            r_seen_b        <= n_seen_b;
            r_stalled       <= n_stalled;
            r_monitoring    <= n_monitoring;
            r_phase_a       <= n_phase_a;
            r_phase_b       <= n_phase_b;
        end
    end

    always_comb begin
        o_result.refresh_pulse  = w_pulse;
        o_result.snapshot_write = w_write;
        o_result.stall_flags    = n_stalled;
        o_result.monitor_active = n_monitoring;
        o_result.phase_a        = n_phase_a;
        o_result.phase_b        = n_phase_b;
        o_result.count_a_low    = n_count_a[LOW_W-1:0];
        o_result.count_b_low    = n_count_b[LOW_W-1:0];
    end

endmodule
